@@ hdl/bpg_pkg.sv @@
// ----------------------------------------------------------------------------
// bpg_pkg: shared types and constants of the button gesture detector
// Holds the request and result structs, command and gesture codes, and the
// struct that carries memory accesses from the sequencer to the entry store.
// ----------------------------------------------------------------------------
package bpg_pkg;

  // Widths fixed by the item fields.
  localparam int PIN_W      = 9;
  localparam int TIME_W     = 16;
  localparam int CMD_W      = 2;
  localparam int BTN_IDX_W  = 4;
  localparam int GEST_W     = 2;
  localparam int MAX_BUTTONS = 16;

  // One store entry: press time above the pending gesture code.
  localparam int ENTRY_W    = TIME_W + GEST_W;
  localparam int MEM_ADDR_W = 4;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Pending gesture codes.
  localparam logic [GEST_W-1:0] GEST_NONE  = 2'd0;
  localparam logic [GEST_W-1:0] GEST_SHORT = 2'd1;
  localparam logic [GEST_W-1:0] GEST_LONG  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_SHORT    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 16'd25;
  localparam logic [TIME_W-1:0] SHORT_RESET    = 16'd1000;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PIN_W-1:0]  button_pins;
    logic [TIME_W-1:0] time_now;
  } item_t;

  typedef struct packed {
    logic                 event_valid;
    logic [BTN_IDX_W-1:0] event_button;
    logic                 event_gesture;
  } result_t;

  typedef struct packed {
    logic                  rd_en;
    logic [MEM_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [MEM_ADDR_W-1:0] wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
  } mem_req_t;

endpackage

@@ hdl/bpg_mem.sv @@
// ----------------------------------------------------------------------------
// bpg_mem: per-button entry store
// One synchronous memory of press times and pending gestures, one read and
// one write per cycle, read data registered. Valid bits make an entry that
// was never written since reset read as zero.
// ----------------------------------------------------------------------------
module bpg_mem #(
  parameter int DEPTH = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bpg_pkg::mem_req_t           req,
  output logic [bpg_pkg::ENTRY_W-1:0] rdata
);
  import bpg_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;

  assign rd_addr = req.rd_addr[AW-1:0];
  assign wr_addr = req.wr_addr[AW-1:0];

  // Entry array write.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= req.wr_data;
    end
  end

  // Valid bits, cleared all at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read; a write to the same entry in the same cycle wins.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (req.wr_en && (wr_addr == rd_addr)) begin
        rdata <= req.wr_data;
      end else if (valid[rd_addr]) begin
        rdata <= mem[rd_addr];
      end else begin
        rdata <= '0;
      end
    end
  end

endmodule

@@ hdl/bpg_seq.sv @@
// ----------------------------------------------------------------------------
// bpg_seq: button scan sequencer
// Takes one request, walks the buttons one per cycle through the entry store
// (read, modify, write back), keeps the pressed and long-press masks, and
// holds the result until the output register takes it.
// ----------------------------------------------------------------------------
module bpg_seq #(
  parameter int BUTTON_COUNT = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  bpg_pkg::item_t              item,
  input  logic [bpg_pkg::TIME_W-1:0]  debounce_ticks,
  input  logic [bpg_pkg::TIME_W-1:0]  short_max_ticks,
  output logic                        done,
  input  logic                        take,
  output bpg_pkg::result_t            res,
  output bpg_pkg::mem_req_t           mreq,
  input  logic [bpg_pkg::ENTRY_W-1:0] rdata
);
  import bpg_pkg::*;

  localparam int AW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int CW = $clog2(BUTTON_COUNT + 1);
  localparam logic [CW-1:0] LAST = CW'(BUTTON_COUNT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]              state;
  logic [CW-1:0]           cnt;
  logic                    pv;
  logic [AW-1:0]           pidx;
  logic [CMD_W-1:0]        cmd_q;
  logic [TIME_W-1:0]       time_q;
  logic [BUTTON_COUNT-1:0] held_q;
  logic [BUTTON_COUNT-1:0] pressed_mask;
  logic [BUTTON_COUNT-1:0] long_mask;
  logic                    found;
  result_t                 res_q;

  logic [MAX_BUTTONS-1:0]  pins_w;
  logic [BUTTON_COUNT-1:0] held_in;
  logic [BUTTON_COUNT-1:0] changed;
  logic [TIME_W-1:0]       ptime;
  logic [GEST_W-1:0]       gest;
  logic [TIME_W-1:0]       held_for;
  logic                    rd_en;
  logic                    wr_en;
  logic [ENTRY_W-1:0]      wr_data;
  logic                    long_set;
  logic                    long_clr;
  logic                    fetch_hit;

  // Buttons without a pin read level 0 and so count as held.
  assign pins_w  = MAX_BUTTONS'(item.button_pins);
  assign held_in = ~pins_w[BUTTON_COUNT-1:0];
  assign changed = held_q ^ pressed_mask;

  assign item_ready = (state == S_IDLE);
  assign done       = (state == S_DONE);
  assign res        = res_q;

  // Entry read for the button at the scan counter.
  assign rd_en = (state == S_SCAN) && (cnt != LAST);

  // Modify step for the button whose entry arrived this cycle.
  assign ptime    = rdata[ENTRY_W-1:GEST_W];
  assign gest     = rdata[GEST_W-1:0];
  assign held_for = time_q - ptime;

  always_comb begin
    wr_en     = 1'b0;
    wr_data   = rdata;
    long_set  = 1'b0;
    long_clr  = 1'b0;
    fetch_hit = 1'b0;
    if ((state == S_SCAN) && pv) begin
      case (cmd_q)
        CMD_SAMPLE: begin
          if (changed[pidx]) begin
            if (held_q[pidx]) begin
              wr_en    = 1'b1;
              wr_data  = {time_q, gest};
              long_clr = 1'b1;
            end else if (!long_mask[pidx] && (held_for > debounce_ticks)) begin
              wr_en   = 1'b1;
              wr_data = {ptime,
                         (held_for <= short_max_ticks) ? GEST_SHORT : GEST_LONG};
            end
          end
        end
        CMD_TICK: begin
          if (pressed_mask[pidx] && !long_mask[pidx] &&
              (held_for > short_max_ticks)) begin
            wr_en    = 1'b1;
            wr_data  = {ptime, GEST_LONG};
            long_set = 1'b1;
          end
        end
        CMD_FETCH: begin
          if (!found && (gest != GEST_NONE)) begin
            wr_en     = 1'b1;
            wr_data   = {ptime, GEST_NONE};
            fetch_hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign mreq.rd_en   = rd_en;
  assign mreq.rd_addr = MEM_ADDR_W'(cnt[AW-1:0]);
  assign mreq.wr_en   = wr_en;
  assign mreq.wr_addr = MEM_ADDR_W'(pidx);
  assign mreq.wr_data = wr_data;

  // Request capture and scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pv    <= 1'b0;
      found <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cnt    <= '0;
            pv     <= 1'b0;
            found  <= 1'b0;
            res_q  <= '0;
            cmd_q  <= item.command;
            time_q <= item.time_now;
            held_q <= held_in;
            state  <= (item.command == CMD_UNUSED) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          cnt  <= cnt + CW'(1);
          pv   <= rd_en;
          pidx <= cnt[AW-1:0];
          if (fetch_hit) begin
            found               <= 1'b1;
            res_q.event_valid   <= 1'b1;
            res_q.event_button  <= BTN_IDX_W'(pidx);
            res_q.event_gesture <= (gest == GEST_LONG);
          end
          if (cnt == LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pressed and long-press masks.
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_mask <= '0;
      long_mask    <= '0;
    end else begin
      if (long_clr) begin
        long_mask[pidx] <= 1'b0;
      end else if (long_set) begin
        long_mask[pidx] <= 1'b1;
      end
      if ((state == S_SCAN) && (cnt == LAST) && (cmd_q == CMD_SAMPLE)) begin
        pressed_mask <= held_q;
      end
    end
  end

  // The write-back entry is never the entry being read in the same cycle.
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (mreq.wr_addr != mreq.rd_addr))
    else $error("entry store read and write hit the same entry");

  // A found event is only ever produced by a fetch request.
  a_event_from_fetch: assert property (@(posedge clk) disable iff (rst)
    (done && res_q.event_valid) |-> (cmd_q == CMD_FETCH))
    else $error("event reported for a non-fetch request");

  // At most one entry is cleared per fetch.
  a_single_fetch: assert property (@(posedge clk) disable iff (rst)
    fetch_hit |=> (found && !fetch_hit))
    else $error("fetch cleared more than one pending event");

endmodule

@@ hdl/button_press_gesture_detector_top.sv @@
// ----------------------------------------------------------------------------
// button_press_gesture_detector_top: short and long press classifier
// Debounces a row of buttons and reports short and long presses on fetch.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come on item_valid/item_ready with a command, the active-low pin
//   vector and the tick time. Every request gives exactly one result on
//   result_valid/result_ready; only a fetch that finds a pending event sets
//   event_valid, carrying the lowest-numbered button and its gesture.
//   Thresholds are set through the APB port: debounce_ticks at address 0,
//   short_max_ticks at address 4. Write them only while the block is idle.
// Timing:
//   A request runs from acceptance through the scan and the done state into
//   the result register; the next request is taken only once that register
//   has taken the result and the sequencer is idle again. The scan runs
//   through the entry store, which reads one button entry a cycle and
//   writes it back the cycle after. An unused command code skips the scan
//   and goes straight to the done state.
// Reset and stalls:
//   Reset clears all masks, pending events and press times and restores the
//   default thresholds. While result_ready is low the finished result waits
//   in the output register; one more request is taken and scanned, then the
//   block holds it until the output register frees up.
// ----------------------------------------------------------------------------
module button_press_gesture_detector_top #(
  parameter int BUTTON_COUNT = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  bpg_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output bpg_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bpg_pkg::*;

  logic [TIME_W-1:0]  debounce_ticks;
  logic [TIME_W-1:0]  short_max_ticks;
  logic               cfg_wr;
  logic               seq_done;
  logic               take;
  result_t            seq_res;
  mem_req_t           mreq;
  logic [ENTRY_W-1:0] rdata;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks  <= DEBOUNCE_RESET;
      short_max_ticks <= SHORT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DEBOUNCE) begin
        debounce_ticks <= pwdata[TIME_W-1:0];
      end else begin
        short_max_ticks <= pwdata[TIME_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SHORT) ? 32'(short_max_ticks) : 32'(debounce_ticks);

  // Output register between the sequencer and the receiver.
  assign take = seq_done && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= seq_res;
    end
  end

  bpg_seq #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .debounce_ticks  (debounce_ticks),
    .short_max_ticks (short_max_ticks),
    .done            (seq_done),
    .take            (take),
    .res             (seq_res),
    .mreq            (mreq),
    .rdata           (rdata)
  );

  bpg_mem #(
    .DEPTH(BUTTON_COUNT)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (rdata)
  );

endmodule

@@ tb/gesture_scoreboard_pkg.sv @@
// ----------------------------------------------------------------------------
// gesture_scoreboard_pkg: expected gestures for the button press detector
// Keeps its own copy of the button state and thresholds, works out the result
// of every accepted request and compares block results in request order.
// ----------------------------------------------------------------------------
package gesture_scoreboard_pkg;

  import bpg_pkg::*;

  localparam int BUTTONS = 9;

  class gesture_scoreboard;
    logic [TIME_W-1:0]  debounce_limit;
    logic [TIME_W-1:0]  short_limit;
    logic [BUTTONS-1:0] held_mask;
    logic [BUTTONS-1:0] long_mask;
    logic [TIME_W-1:0]  press_stamp [BUTTONS];
    logic [GEST_W-1:0]  pending [BUTTONS];
    result_t            expected_events [$];
    int unsigned        failures;

    function new();
      debounce_limit = DEBOUNCE_RESET;
      short_limit    = SHORT_RESET;
      held_mask      = '0;
      long_mask      = '0;
      failures       = 0;
      foreach (press_stamp[b]) press_stamp[b] = '0;
      foreach (pending[b]) pending[b] = GEST_NONE;
    endfunction

    function void set_threshold(logic idx, logic [TIME_W-1:0] value);
      if (idx == REG_DEBOUNCE) begin
        debounce_limit = value;
      end else begin
        short_limit = value;
      end
    endfunction

    // Apply one accepted request to the button state and queue its result.
    function void note_request(item_t req);
      result_t            outcome;
      logic [BUTTONS-1:0] held;
      logic [BUTTONS-1:0] changed;
      logic [TIME_W-1:0]  held_for;
      bit                 found;
      outcome = '0;
      found   = 1'b0;
      case (req.command)
        CMD_SAMPLE: begin
          held    = ~req.button_pins[BUTTONS-1:0];
          changed = held ^ held_mask;
          for (int b = 0; b < BUTTONS; b++) begin
            if (changed[b] && held[b]) begin
              press_stamp[b] = req.time_now;
              long_mask[b]   = 1'b0;
            end else if (changed[b]) begin
              // Release: only a hold past the debounce time that has not
              // already produced a long press counts.
              held_for = req.time_now - press_stamp[b];
              if (!long_mask[b] && held_for > debounce_limit) begin
                pending[b] = (held_for <= short_limit) ? GEST_SHORT : GEST_LONG;
              end
            end
          end
          held_mask = held;
        end
        CMD_TICK: begin
          for (int b = 0; b < BUTTONS; b++) begin
            held_for = req.time_now - press_stamp[b];
            if (held_mask[b] && !long_mask[b] && held_for > short_limit) begin
              long_mask[b] = 1'b1;
              pending[b]   = GEST_LONG;
            end
          end
        end
        CMD_FETCH: begin
          // The lowest-numbered pending event wins.
          for (int b = 0; b < BUTTONS; b++) begin
            if (!found && pending[b] != GEST_NONE) begin
              found                 = 1'b1;
              outcome.event_valid   = 1'b1;
              outcome.event_button  = BTN_IDX_W'(b);
              outcome.event_gesture = (pending[b] == GEST_LONG);
              pending[b]            = GEST_NONE;
            end
          end
        end
        default: begin
          // The unused command leaves everything as it is.
        end
      endcase
      expected_events.push_back(outcome);
    endfunction

    // Compare one result from the block with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        failures++;
        $display("%0t: unexpected result valid=%0b button=%0d gesture=%0b",
                 $time, got.event_valid, got.event_button, got.event_gesture);
      end else begin
        want = expected_events.pop_front();
        if (got.event_valid !== want.event_valid ||
            got.event_button !== want.event_button ||
            got.event_gesture !== want.event_gesture) begin
          failures++;
          $display("%0t: mismatch, expected %0b/%0d/%0b, actual %0b/%0d/%0b",
                   $time, want.event_valid, want.event_button, want.event_gesture,
                   got.event_valid, got.event_button, got.event_gesture);
        end
      end
    endfunction
  endclass

endpackage

@@ tb/button_press_gesture_detector_top_tb.sv @@
// ----------------------------------------------------------------------------
// button_press_gesture_detector_top_tb: gesture detector testbench
// Runs directed press, release, tick and fetch requests, then random button
// activity under several threshold settings, with random idling on both
// channels and one long result stall. Every result is checked in order.
// ----------------------------------------------------------------------------
module button_press_gesture_detector_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bpg_pkg::*;
  import gesture_scoreboard_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          CALM_FIRST   = 500;
  localparam int          CALM_LAST    = 700;
  localparam int          STALL_AT     = 800;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gesture_scoreboard  sb;
  logic               calm = 1'b0;
  int                 stall_asks = 0;
  int                 stall_done = 0;
  int unsigned        cycle_count = 0;
  int                 random_sent = 0;
  logic [BUTTONS-1:0] pin_state;
  logic [TIME_W-1:0]  tick_time;
  logic [TIME_W-1:0]  cur_debounce;
  logic [TIME_W-1:0]  cur_short;

  button_press_gesture_detector_top #(
    .BUTTON_COUNT(BUTTONS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Note accepted requests and check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        sb.check_result(result);
      end
      if (item_valid && item_ready) begin
        sb.note_request(item);
      end
    end
  end

  // Result side: random stalls, none while calm, and a long hold on request.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asks != stall_done) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        stall_done++;
      end else begin
        result_ready <= calm || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 12);
  endfunction

  // Time advance sized against the current thresholds so that holds land on
  // both sides of the debounce and short press limits.
  function automatic int unsigned time_step();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      return $urandom_range(0, cur_debounce + 3);
    end else if (roll < 75) begin
      return $urandom_range(0, cur_short / 3 + 4);
    end else if (roll < 95) begin
      return $urandom_range(0, cur_short + cur_short / 4 + 4);
    end
    return $urandom_range(0, 65535);
  endfunction

  // Offer one request; starts and ends at a falling edge.
  task automatic send_request(input item_t req);
    while (take_gap()) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [PIN_W-1:0] pins,
                             input logic [TIME_W-1:0] stamp);
    item_t req;
    req.command     = cmd;
    req.button_pins = pins;
    req.time_now    = stamp;
    send_request(req);
  endtask

  // Wait until every result is back and the block has settled.
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write: setup then access; psel is left high for the caller to drop.
  task automatic apb_write(input logic idx, input logic [TIME_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_threshold(idx, value);
    if (idx == REG_DEBOUNCE) begin
      cur_debounce = value;
    end else begin
      cur_short = value;
    end
    @(negedge clk);
  endtask

  // One random request: mostly button toggles, ticks and fetches on a
  // moving clock, with some noise samples and unused commands.
  task automatic send_random_item();
    item_t       req;
    int unsigned roll;
    roll            = $urandom_range(0, 99);
    tick_time       = tick_time + TIME_W'(time_step());
    req.time_now    = tick_time;
    req.button_pins = PIN_W'($urandom);
    if (roll < 45) begin
      req.command = CMD_SAMPLE;
      if ($urandom_range(0, 99) < 70) begin
        pin_state[$urandom_range(0, BUTTONS - 1)] ^= 1'b1;
      end else begin
        pin_state ^= PIN_W'($urandom_range(1, 511));
      end
      req.button_pins = pin_state;
    end else if (roll < 68) begin
      req.command = CMD_TICK;
    end else if (roll < 90) begin
      req.command = CMD_FETCH;
    end else if (roll < 96) begin
      req.command  = CMD_SAMPLE;
      req.time_now = TIME_W'($urandom);
      pin_state    = req.button_pins;
    end else begin
      req.command = CMD_UNUSED;
    end
    send_request(req);
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] debounce, input logic [TIME_W-1:0] hold,
                           input int count);
    drain();
    apb_write(REG_DEBOUNCE, debounce);
    apb_write(REG_SHORT, hold);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    repeat (count) begin
      if (random_sent == CALM_FIRST) calm <= 1'b1;
      if (random_sent == CALM_LAST) calm <= 1'b0;
      if (random_sent == STALL_AT) stall_asks <= stall_asks + 1;
      send_random_item();
      random_sent++;
    end
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pin_state    = '1;
    tick_time    = '0;
    cur_debounce = DEBOUNCE_RESET;
    cur_short    = SHORT_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset thresholds.
    send_fields(CMD_FETCH, 9'h1FF, 16'd0);        // nothing pending
    send_fields(CMD_SAMPLE, 9'h1FE, 16'd100);     // press button 0
    send_fields(CMD_SAMPLE, 9'h1FF, 16'd125);     // bounce at the debounce limit
    send_fields(CMD_SAMPLE, 9'h1FE, 16'd200);
    send_fields(CMD_SAMPLE, 9'h1FF, 16'd226);     // just past debounce: short
    send_fields(CMD_SAMPLE, 9'h0FF, 16'd300);     // press button 8
    send_fields(CMD_SAMPLE, 9'h1FF, 16'd1300);    // exactly the short limit
    send_fields(CMD_SAMPLE, 9'h0FF, 16'd2000);
    send_fields(CMD_SAMPLE, 9'h1FF, 16'd3001);    // long replaces pending short
    send_fields(CMD_SAMPLE, 9'h1F7, 16'd65500);   // press button 3 near wrap
    send_fields(CMD_TICK, 9'h000, 16'd964);       // held exactly the limit
    send_fields(CMD_TICK, 9'h155, 16'd965);       // long press from the tick
    send_fields(CMD_TICK, 9'h0AA, 16'd5000);      // no second long press
    send_fields(CMD_SAMPLE, 9'h1FF, 16'd6000);    // release after long: nothing
    send_fields(CMD_FETCH, 9'h000, 16'hFFFF);
    send_fields(CMD_FETCH, 9'h1FF, 16'd0);
    send_fields(CMD_FETCH, 9'h0F0, 16'h8000);
    send_fields(CMD_FETCH, 9'h00F, 16'h7FFF);     // empty again
    send_fields(CMD_UNUSED, 9'h000, 16'hFFFF);    // ignored
    send_fields(CMD_SAMPLE, 9'h000, 16'hFFF0);    // press every button
    send_fields(CMD_SAMPLE, 9'h1FF, 16'h0010);    // release across the wrap
    send_fields(CMD_FETCH, 9'h1FF, 16'h0020);
    send_fields(CMD_FETCH, 9'h1FF, 16'h0030);
    send_fields(CMD_FETCH, 9'h1FF, 16'h0040);
    pin_state = '1;
    tick_time = 16'h0040;

    // Random part under several threshold settings.
    run_phase(16'd0, 16'd0, 250);
    run_phase(16'hFFFF, 16'hFFFF, 150);
    run_phase(16'd20, 16'd300, 500);
    run_phase(TIME_W'($urandom_range(0, 200)), TIME_W'($urandom_range(0, 2000)), 400);
    run_phase(DEBOUNCE_RESET, SHORT_RESET, 200);
    drain();

    if (sb.failures == 0 && sb.expected_events.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ button_press_gesture_detector_top.f @@
hdl/bpg_pkg.sv
hdl/bpg_mem.sv
hdl/bpg_seq.sv
hdl/button_press_gesture_detector_top.sv
tb/gesture_scoreboard_pkg.sv
tb/button_press_gesture_detector_top_tb.sv
